[rtl/core/ets2c_pkg.sv]
// Shared types, widths and constants of the epoch seconds to calendar converter.
`timescale 1ns / 1ps
package ets2c_pkg;

  // Field and internal widths
  localparam int ZONE_W  = 17;
  localparam int EPOCH_W = 32;
  localparam int TIME_W  = 33;  // saturated local time, never negative
  localparam int DAYS_W  = 16;  // whole days since 1970, at most 49711
  localparam int SOD_W   = 17;  // second of day, below 86400
  localparam int REMH_W  = 12;  // second within the hour, below 3600
  localparam int DOE_W   = 18;  // day of 400-year era, below 146097
  localparam int YOE_W   = 9;   // year of era, below 400
  localparam int DOY_W   = 9;   // day of March-based year, below 366

  localparam logic signed [ZONE_W-1:0] ZONE_RESET = 17'sd28800;

  // Days are split as (t >> 7) / 675, since 86400 = 128 * 675
  localparam logic [26:0] DAY_RECIP  = 27'd101806632;  // floor(2^36 / 675)
  localparam int          DAY_SHIFT  = 36;
  localparam logic [9:0]  DAY_ODD    = 10'd675;

  // Reciprocals, rounded up, exact over the operand ranges used here
  localparam logic [15:0] HOUR_RECIP = 16'd37283;   // 2^27 / 3600
  localparam logic [14:0] MIN_RECIP  = 15'd17477;   // 2^20 / 60
  localparam logic [16:0] WEEK_RECIP = 17'd74899;   // 2^19 / 7
  localparam logic [17:0] Q4Y_RECIP  = 18'd183860;  // 2^28 / 1460 and 2^26 / 365
  localparam logic [12:0] MP_RECIP   = 13'd6854;    // 2^20 / 153

  // Civil date constants
  localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;  // 0000-03-01 to 1970-01-01
  localparam logic [19:0] ERA5_START   = 20'd730485;  // 5 * 146097
  localparam logic [19:0] ERA4_START   = 20'd584388;  // 4 * 146097
  localparam logic [17:0] CENT_DAYS    = 18'd36524;
  localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
  localparam logic [11:0] YEAR_ERA4    = 12'd1600;
  localparam logic [11:0] YEAR_ERA5    = 12'd2000;

  // Extra stages that align time of day with the longer date path
  localparam int TOD_PAD = 3;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_seconds;
  } stamp_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second_of_minute;
    logic [2:0]  weekday;
  } calendar_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second_of_minute;
  } tod_t;

  // First day of each month in a year that starts on 1 March
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/ets2c_stream_if.sv]
// Valid/ready stream interface used for both channels of the converter.
`timescale 1ns / 1ps
interface ets2c_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ets2c_split.sv]
// Zone offset, saturation and split of local time into days and second of day.
`timescale 1ns / 1ps
module ets2c_split (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [ets2c_pkg::EPOCH_W-1:0]       epoch,
  input  logic signed [ets2c_pkg::ZONE_W-1:0] zone,
  output logic                                out_valid,
  output logic [ets2c_pkg::DAYS_W-1:0]        days,
  output logic [ets2c_pkg::SOD_W-1:0]         sod
);
  import ets2c_pkg::*;

  logic                 v1, v2, v3;
  logic signed [TIME_W:0] sum;
  logic [TIME_W-1:0]    t1;
  logic [25:0]          x_in;
  logic [52:0]          prod;
  logic [DAYS_W-1:0]    q2;
  logic [25:0]          x2;
  logic [6:0]           lo2;
  logic [25:0]          qm;
  logic [25:0]          rem_full;
  logic [10:0]          rem;
  logic                 fix;
  logic [9:0]           rem_fixed;
  logic [DAYS_W-1:0]    days3;
  logic [SOD_W-1:0]     sod3;

  // Stage 1: add offset at full width, clamp negatives to zero
  assign sum = $signed({2'b00, epoch}) + $signed({{(TIME_W+1-ZONE_W){zone[ZONE_W-1]}}, zone});

  always_ff @(posedge clk) begin
    if (adv) begin
      t1 <= sum[TIME_W] ? '0 : sum[TIME_W-1:0];
    end
  end

  // Stage 2: estimate of (t >> 7) / 675, low by at most one
  assign x_in = t1[TIME_W-1:7];
  assign prod = 53'(x_in) * 53'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      q2  <= prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
      x2  <= x_in;
      lo2 <= t1[6:0];
    end
  end

  // Stage 3: remainder and one correction step
  assign qm        = 26'(q2) * 26'(DAY_ODD);
  assign rem_full  = x2 - qm;
  assign rem       = rem_full[10:0];
  assign fix       = rem >= 11'(DAY_ODD);
  assign rem_fixed = fix ? 10'(rem - 11'(DAY_ODD)) : rem[9:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      days3 <= q2 + DAYS_W'(fix);
      sod3  <= {rem_fixed, lo2};
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;
  assign days      = days3;
  assign sod       = sod3;
endmodule

[rtl/core/ets2c_tod.sv]
// Hour, minute and second from the second of day, padded to the date latency.
`timescale 1ns / 1ps
module ets2c_tod (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [ets2c_pkg::SOD_W-1:0] sod,
  output ets2c_pkg::tod_t             tod
);
  import ets2c_pkg::*;

  logic [32:0]       hp;
  logic [SOD_W-1:0]  sod1;
  logic [4:0]        hour1, hour2, hour3;
  logic [SOD_W-1:0]  hsec;
  logic [SOD_W-1:0]  remh_full;
  logic [REMH_W-1:0] rem2, rem3;
  logic [26:0]       mp;
  logic [5:0]        min3;
  logic [REMH_W-1:0] msec;
  logic [REMH_W-1:0] sec_full;
  tod_t              tod4;
  tod_t              pad [TOD_PAD];

  // T1: hour by reciprocal
  assign hp = 33'(sod) * 33'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      sod1  <= sod;
      hour1 <= hp[31:27];
    end
  end

  // T2: second within the hour
  assign hsec      = SOD_W'(hour1) * SOD_W'(3600);
  assign remh_full = sod1 - hsec;

  always_ff @(posedge clk) begin
    if (adv) begin
      hour2 <= hour1;
      rem2  <= remh_full[REMH_W-1:0];
    end
  end

  // T3: minute by reciprocal
  assign mp = 27'(rem2) * 27'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      hour3 <= hour2;
      rem3  <= rem2;
      min3  <= mp[25:20];
    end
  end

  // T4: second within the minute
  assign msec     = REMH_W'(min3) * REMH_W'(60);
  assign sec_full = rem3 - msec;

  always_ff @(posedge clk) begin
    if (adv) begin
      tod4.hour             <= hour3;
      tod4.minute           <= min3;
      tod4.second_of_minute <= sec_full[5:0];
    end
  end

  // Delay line to line up with the date path
  always_ff @(posedge clk) begin
    if (adv) begin
      pad[0] <= tod4;
      for (int i = 1; i < TOD_PAD; i++) begin
        pad[i] <= pad[i-1];
      end
    end
  end

  assign tod = pad[TOD_PAD-1];
endmodule

[rtl/core/ets2c_date.sv]
// Gregorian date and weekday from the day count, seven register stages.
`timescale 1ns / 1ps
module ets2c_date (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [ets2c_pkg::DAYS_W-1:0] days,
  output logic                         out_valid,
  output logic [11:0]                  year,
  output logic [3:0]                   month,
  output logic [4:0]                   day_of_month,
  output logic [2:0]                   weekday
);
  import ets2c_pkg::*;

  localparam int STAGES = 7;

  logic [STAGES-1:0] v;

  // D1 signals
  logic [19:0]       z;
  logic              era_hi;
  logic [19:0]       doe_full;
  logic [DAYS_W-1:0] wv;
  logic [32:0]       wp;
  logic [DOE_W-1:0]  doe1;
  logic              era1;
  logic [DAYS_W-1:0] wv1;
  logic [12:0]       wq1;
  // D2 signals
  logic [35:0]       ap;
  logic [2:0]        cents;
  logic [DAYS_W-1:0] w7;
  logic [DAYS_W-1:0] wd_full;
  logic [DOE_W-1:0]  doe2;
  logic [6:0]        a2;
  logic [2:0]        b2;
  logic              c2;
  logic              era2;
  logic [2:0]        wd2;
  // D3 signals
  logic [DOE_W-1:0]  n3, doe3;
  logic              era3;
  logic [2:0]        wd3;
  // D4 signals
  logic [35:0]       yp;
  logic [YOE_W-1:0]  yoe4;
  logic [DOE_W-1:0]  doe4;
  logic              era4;
  logic [2:0]        wd4;
  // D5 signals
  logic [1:0]        ycent;
  logic [DOE_W-1:0]  ybase_days;
  logic [DOE_W-1:0]  doy_full;
  logic [DOY_W-1:0]  doy5;
  logic [YOE_W-1:0]  yoe5;
  logic              era5;
  logic [2:0]        wd5;
  // D6 signals
  logic [10:0]       mnum;
  logic [23:0]       mprod;
  logic [3:0]        mp6;
  logic [DOY_W-1:0]  doy6;
  logic [11:0]       ybase6;
  logic [2:0]        wd6;
  // D7 signals
  logic [DOY_W-1:0]  dom_full;
  logic              jan_feb;

  // D1: shift to a March-based era, weekday quotient
  assign z        = 20'(days) + EPOCH_SHIFT;
  assign era_hi   = z >= ERA5_START;
  assign doe_full = z - (era_hi ? ERA5_START : ERA4_START);
  assign wv       = days + DAYS_W'(4);
  assign wp       = 33'(wv) * 33'(WEEK_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      doe1 <= doe_full[DOE_W-1:0];
      era1 <= era_hi;
      wv1  <= wv;
      wq1  <= wp[31:19];
    end
  end

  // D2: leap-day corrections of the era, weekday remainder
  assign ap = 36'(doe1) * 36'(Q4Y_RECIP);

  always_comb begin
    if (doe1 >= ERA_LAST_DAY) begin
      cents = 3'd4;
    end else if (doe1 >= 18'(3 * CENT_DAYS)) begin
      cents = 3'd3;
    end else if (doe1 >= 18'(2 * CENT_DAYS)) begin
      cents = 3'd2;
    end else if (doe1 >= CENT_DAYS) begin
      cents = 3'd1;
    end else begin
      cents = 3'd0;
    end
  end

  assign w7      = DAYS_W'(wq1) * DAYS_W'(7);
  assign wd_full = wv1 - w7;

  always_ff @(posedge clk) begin
    if (adv) begin
      doe2 <= doe1;
      a2   <= ap[34:28];
      b2   <= cents;
      c2   <= doe1 == ERA_LAST_DAY;
      era2 <= era1;
      wd2  <= wd_full[2:0];
    end
  end

  // D3: day count with leap days taken out
  always_ff @(posedge clk) begin
    if (adv) begin
      n3   <= doe2 - DOE_W'(a2) + DOE_W'(b2) - DOE_W'(c2);
      doe3 <= doe2;
      era3 <= era2;
      wd3  <= wd2;
    end
  end

  // D4: year of era
  assign yp = 36'(n3) * 36'(Q4Y_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      yoe4 <= yp[34:26];
      doe4 <= doe3;
      era4 <= era3;
      wd4  <= wd3;
    end
  end

  // D5: day of the March-based year
  always_comb begin
    if (yoe4 >= 9'd300) begin
      ycent = 2'd3;
    end else if (yoe4 >= 9'd200) begin
      ycent = 2'd2;
    end else if (yoe4 >= 9'd100) begin
      ycent = 2'd1;
    end else begin
      ycent = 2'd0;
    end
  end

  assign ybase_days = DOE_W'(yoe4) * DOE_W'(365) + DOE_W'(yoe4[YOE_W-1:2]) - DOE_W'(ycent);
  assign doy_full   = doe4 - ybase_days;

  always_ff @(posedge clk) begin
    if (adv) begin
      doy5 <= doy_full[DOY_W-1:0];
      yoe5 <= yoe4;
      era5 <= era4;
      wd5  <= wd4;
    end
  end

  // D6: month index from day of year, calendar year of the March year
  assign mnum  = 11'(doy5) * 11'(5) + 11'(2);
  assign mprod = 24'(mnum) * 24'(MP_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      mp6    <= mprod[23:20];
      doy6   <= doy5;
      ybase6 <= 12'(yoe5) + (era5 ? YEAR_ERA5 : YEAR_ERA4);
      wd6    <= wd5;
    end
  end

  // D7: day of month, month, January and February roll into the next year
  assign dom_full = doy6 - month_start(mp6) + DOY_W'(1);
  assign jan_feb  = mp6 >= 4'd10;

  always_ff @(posedge clk) begin
    if (adv) begin
      day_of_month <= dom_full[4:0];
      month        <= jan_feb ? mp6 - 4'd9 : mp6 + 4'd3;
      year         <= ybase6 + 12'(jan_feb);
      weekday      <= wd6;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = v[STAGES-1];
endmodule

[rtl/core/epoch_seconds_to_calendar.sv]
// Top level: Unix time to local Gregorian calendar date and time of day.
//
// Usage:
//   stamp    : sink channel; one transaction carries epoch_seconds (unsigned
//              seconds since 1970-01-01 00:00:00 UTC).
//   calendar : source channel; one transaction per input with year, month,
//              day_of_month, hour, minute, second_of_minute and weekday
//              (0 is Sunday).
//   cfg_write_en / cfg_write_data : signed 17-bit zone offset in seconds,
//              added before conversion; write it only while idle.
// A negative local time clamps to 1970-01-01 00:00:00, Thursday.
// Throughput is one transaction per cycle while calendar is not stalled. The
// pipeline has ten register stages between an accepted input and its result.
// The depth is set by the day division (three stages) followed by the
// seven-stage civil date path; time of day runs alongside it.
// Reset empties the pipeline and loads the offset with +28800 (UTC+8).
// When calendar is stalled the whole pipeline holds; stamp.ready follows
// calendar.ready while a result waits, so nothing is lost or repeated.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar (
  input  logic                                clk,
  input  logic                                rst,
  ets2c_stream_if.sink                        stamp,
  ets2c_stream_if.source                      calendar,
  input  logic                                cfg_write_en,
  input  logic signed [ets2c_pkg::ZONE_W-1:0] cfg_write_data
);
  import ets2c_pkg::*;

  logic signed [ZONE_W-1:0] zone;
  logic                     adv;
  logic                     split_valid;
  logic [DAYS_W-1:0]        days;
  logic [SOD_W-1:0]         sod;
  tod_t                     tod;
  logic                     date_valid;
  logic [11:0]              year;
  logic [3:0]               month;
  logic [4:0]               day_of_month;
  logic [2:0]               weekday;

  // Zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= ZONE_RESET;
    end else if (cfg_write_en) begin
      zone <= cfg_write_data;
    end
  end

  // Pipeline advances unless the last stage holds an untaken result
  assign adv         = !date_valid || calendar.ready;
  assign stamp.ready = adv;

  ets2c_split u_split (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (stamp.valid),
    .epoch     (stamp.data.epoch_seconds),
    .zone      (zone),
    .out_valid (split_valid),
    .days      (days),
    .sod       (sod)
  );

  ets2c_tod u_tod (
    .clk (clk),
    .adv (adv),
    .sod (sod),
    .tod (tod)
  );

  ets2c_date u_date (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (split_valid),
    .days         (days),
    .out_valid    (date_valid),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday)
  );

  // Result assembly
  assign calendar.valid                  = date_valid;
  assign calendar.data.year              = year;
  assign calendar.data.month             = month;
  assign calendar.data.day_of_month      = day_of_month;
  assign calendar.data.hour              = tod.hour;
  assign calendar.data.minute            = tod.minute;
  assign calendar.data.second_of_minute  = tod.second_of_minute;
  assign calendar.data.weekday           = weekday;

`ifndef SYNTHESIS
  // Date fields stay in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    calendar.valid |-> (year >= 12'd1970 && month >= 4'd1 && month <= 4'd12 &&
                        day_of_month >= 5'd1 && day_of_month <= 5'd31))
    else $error("date field out of range");

  // Time of day and weekday stay in range
  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    calendar.valid |-> (tod.hour <= 5'd23 && tod.minute <= 6'd59 &&
                        tod.second_of_minute <= 6'd59 && weekday <= 3'd6))
    else $error("time of day or weekday out of range");

  // 29 February only in years divisible by four
  a_leap_day: assert property (@(posedge clk) disable iff (rst)
    (calendar.valid && month == 4'd2 && day_of_month == 5'd29) |-> (year[1:0] == 2'b00))
    else $error("29 February in a common year");

  // February never runs past the 29th
  a_feb_len: assert property (@(posedge clk) disable iff (rst)
    (calendar.valid && month == 4'd2) |-> (day_of_month <= 5'd29))
    else $error("February day beyond 29");
`endif
endmodule
